@@ design/bouncing_particle_table_unit_macros.svh @@
// Assertion macros shared by the particle table RTL.
`ifndef BOUNCING_PARTICLE_TABLE_UNIT_MACROS_SVH
`define BOUNCING_PARTICLE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BPTU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define BPTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bptu_pkg.sv @@
// Shared types and constants of the bouncing particle table.
`default_nettype none
package bptu_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  // item opcodes
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // config register indexes
  localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FRAME_STEP   = 2'd2;

  // config reset values
  localparam logic [7:0]  PANEL_WIDTH_RST  = 8'd64;
  localparam logic [7:0]  PANEL_HEIGHT_RST = 8'd32;
  localparam logic [15:0] FRAME_STEP_RST   = 16'd1092;

  // velocity limits for saturating negation
  localparam logic signed [16:0] VEL_MIN = {1'b1, 16'h0000};
  localparam logic signed [16:0] VEL_MAX = {1'b0, 16'hFFFF};

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_SPAWN_OK   = 2'd1,
    KIND_SPAWN_FULL = 2'd2
  } kind_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } particle_t;

  localparam int PART_W = $bits(particle_t);

endpackage
`default_nettype wire

@@ design/bptu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bptu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/bptu_axis.sv @@
// One axis of the particle update: move, bounce, clamp and pixel select.
`default_nettype none
module bptu_axis import bptu_pkg::*; (
  input  wire logic signed [32:0] prod,     // velocity times frame step
  input  wire logic [23:0]        pos,
  input  wire logic signed [16:0] vel,
  input  wire logic [7:0]         size,
  output logic [23:0]             new_pos,
  output logic signed [16:0]      new_vel,
  output logic [7:0]              pixel
);

  logic signed [24:0] delta;
  logic signed [26:0] sum;
  logic signed [26:0] lim;
  logic signed [26:0] refl;
  logic signed [26:0] clamped;
  logic               flip;
  logic [7:0]         ipart;

  // floor of prod / 256 is an arithmetic shift
  assign delta = prod[32:8];
  assign sum   = $signed({3'b000, pos}) + {{2{delta[24]}}, delta};
  assign lim   = $signed({3'b000, size, 16'h0000});

  // mirror at the low or high edge
  always_comb begin
    flip = 1'b0;
    refl = sum;
    if (sum < 27'sd0) begin
      refl = -sum;
      flip = 1'b1;
    end else if (sum > lim) begin
      refl = (lim <<< 1) - sum;
      flip = 1'b1;
    end
  end

  // clamp into [0, edge]
  always_comb begin
    if (refl < 27'sd0) begin
      clamped = '0;
    end else if (refl > lim) begin
      clamped = lim;
    end else begin
      clamped = refl;
    end
  end

  assign new_pos = clamped[23:0];

  // saturating negation on a bounce
  always_comb begin
    if (!flip) begin
      new_vel = vel;
    end else if (vel == VEL_MIN) begin
      new_vel = VEL_MAX;
    end else begin
      new_vel = -vel;
    end
  end

  // position never exceeds the edge, so the modulo only wraps size to zero
  assign ipart = new_pos[23:16];
  assign pixel = (ipart == size) ? 8'd0 : ipart;

endmodule
`default_nettype wire

@@ design/bouncing_particle_table_unit.sv @@
// Bouncing particle table: spawn and frame items in, pixel and status items out.
//
// Input channel (item_valid / item_stall) carries one item: op 0 spawns a
// particle, op 1 advances every stored particle one frame and draws it.
// Output channel (result_valid / result_stall) carries result items.
// A spawn gives one status item (accepted or table full) with last set; it
// is written into the table, if there is room, and answered in the cycle it
// is accepted, so the status item shows in the next cycle. A frame walks the
// table RAM with one read per particle and one pixel item per particle, last
// on the final one; an empty table gives no item. The walk is paced by the
// single read port of the table RAM and a three-stage read / multiply /
// bounce pipeline. Items are taken one at a time; a new item is accepted
// once the walk is over and the output register is free or being taken. A
// stall on the output freezes the whole walk pipeline. Reset holds item_stall
// high, empties the table and restores the panel size and frame step
// defaults; RAM contents are not cleared, only the count. Configuration
// writes are taken at any time but must come while idle.
`default_nettype none
`include "bouncing_particle_table_unit_macros.svh"
module bouncing_particle_table_unit import bptu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // input items
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               op,
  input  wire logic [23:0]        spawn_x,
  input  wire logic [23:0]        spawn_y,
  input  wire logic signed [16:0] spawn_vx,
  input  wire logic signed [16:0] spawn_vy,
  input  wire logic [7:0]         spawn_red,
  input  wire logic [7:0]         spawn_green,
  input  wire logic [7:0]         spawn_blue,
  // result items
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              kind,
  output logic [7:0]              pixel_x,
  output logic [7:0]              pixel_y,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic                    last
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t state;

  // configuration registers
  logic [7:0]  panel_width;
  logic [7:0]  panel_height;
  logic [15:0] frame_step;

  // table fill and walk control
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] iss;
  logic [CNT_W-1:0] iss_inc;
  logic             iss_more;

  // pipeline stage 1: RAM data valid
  logic             v1;
  logic [IDX_W-1:0] a1;
  logic             l1;
  // pipeline stage 2: products registered
  logic             v2;
  logic [IDX_W-1:0] a2;
  logic             l2;
  particle_t        e2;
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;

  // output register
  kind_t       o_kind;
  logic [7:0]  o_px;
  logic [7:0]  o_py;
  logic [7:0]  o_r;
  logic [7:0]  o_g;
  logic [7:0]  o_b;
  logic        o_last;

  // RAM ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [PART_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [PART_W-1:0]   ram_rdata;
  particle_t           e1;
  particle_t           spawn_entry;
  particle_t           upd_entry;

  // multiplier operands
  logic signed [32:0]  step33;
  logic signed [32:0]  vx33;
  logic signed [32:0]  vy33;

  // bounce results
  logic [23:0]         nx_pos;
  logic [23:0]         ny_pos;
  logic signed [16:0]  nx_vel;
  logic signed [16:0]  ny_vel;
  logic [7:0]          px;
  logic [7:0]          py;

  logic adv;
  logic accept;
  logic spawn_acc;
  logic spawn_room;
  logic frame_acc;
  logic wb;

  // pipeline moves when the output register is free or being taken
  assign adv        = !result_valid || !result_stall;
  assign item_stall = rst || (state == ST_WALK) || !adv;
  assign accept     = item_valid && !item_stall;
  assign spawn_acc  = accept && (op == OP_SPAWN);
  assign frame_acc  = accept && (op == OP_FRAME);
  assign spawn_room = (count < CNT_W'(MAX_PARTICLES));

  assign iss_inc  = iss + 1'b1;
  assign iss_more = (iss < count);
  assign wb       = (state == ST_WALK) && adv && v2;

  // table RAM
  assign spawn_entry = '{pos_x: spawn_x, pos_y: spawn_y, vel_x: spawn_vx,
                         vel_y: spawn_vy, red: spawn_red, green: spawn_green,
                         blue: spawn_blue};
  assign upd_entry   = '{pos_x: nx_pos, pos_y: ny_pos, vel_x: nx_vel,
                         vel_y: ny_vel, red: e2.red, green: e2.green,
                         blue: e2.blue};

  assign ram_we    = (spawn_acc && spawn_room) || wb;
  assign ram_waddr = wb ? a2 : count[IDX_W-1:0];
  assign ram_wdata = wb ? upd_entry : spawn_entry;
  assign ram_re    = (state == ST_WALK) && adv && iss_more;
  assign e1        = particle_t'(ram_rdata);

  bptu_ram #(
    .WIDTH (PART_W),
    .DEPTH (MAX_PARTICLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // multiplier operands: velocities sign-extended, frame step zero-extended
  assign step33 = $signed({17'b0, frame_step});
  assign vx33   = {{16{e1.vel_x[16]}}, e1.vel_x};
  assign vy33   = {{16{e1.vel_y[16]}}, e1.vel_y};

  // bounce logic per axis
  bptu_axis u_axis_x (
    .prod    (prod_x),
    .pos     (e2.pos_x),
    .vel     (e2.vel_x),
    .size    (panel_width),
    .new_pos (nx_pos),
    .new_vel (nx_vel),
    .pixel   (px)
  );

  bptu_axis u_axis_y (
    .prod    (prod_y),
    .pos     (e2.pos_y),
    .vel     (e2.vel_y),
    .size    (panel_height),
    .new_pos (ny_pos),
    .new_vel (ny_vel),
    .pixel   (py)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
      frame_step   <= FRAME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data[7:0];
        CFG_PANEL_HEIGHT: panel_height <= cfg_data[7:0];
        CFG_FRAME_STEP:   frame_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk) begin
    if (state == ST_WALK && adv) begin
      if (ram_re) begin
        a1 <= iss[IDX_W-1:0];
        l1 <= (iss_inc == count);
      end
      a2     <= a1;
      l2     <= l1;
      e2     <= e1;
      prod_x <= vx33 * step33;
      prod_y <= vy33 * step33;
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      iss          <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (adv) begin
            result_valid <= spawn_acc;
          end
          if (spawn_acc) begin
            o_kind <= spawn_room ? KIND_SPAWN_OK : KIND_SPAWN_FULL;
            o_px   <= '0;
            o_py   <= '0;
            o_r    <= '0;
            o_g    <= '0;
            o_b    <= '0;
            o_last <= 1'b1;
            if (spawn_room) begin
              count <= count + 1'b1;
            end
          end
          if (frame_acc && count != '0) begin
            state <= ST_WALK;
            iss   <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
          end
        end
        ST_WALK: begin
          if (adv) begin
            v1 <= iss_more;
            v2 <= v1;
            if (iss_more) begin
              iss <= iss_inc;
            end
            result_valid <= v2;
            if (v2) begin
              o_kind <= KIND_PIXEL;
              o_px   <= px;
              o_py   <= py;
              o_r    <= e2.red;
              o_g    <= e2.green;
              o_b    <= e2.blue;
              o_last <= l2;
            end
            // last read issued and stage 1 empty: stage 2 drains now
            if (!iss_more && !v1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign kind    = o_kind;
  assign pixel_x = o_px;
  assign pixel_y = o_py;
  assign red     = o_r;
  assign green   = o_g;
  assign blue    = o_b;
  assign last    = o_last;

  // checks
  `BPTU_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_PARTICLES), "count over table size")
  `BPTU_ASSERT_NOW(a_no_rw_clash, clk, rst, ram_we && ram_re, ram_waddr != iss[IDX_W-1:0], "read and write hit one entry")
  `BPTU_ASSERT_NEXT(a_wb_emits, clk, rst, wb, result_valid && o_kind == KIND_PIXEL, "write-back without pixel item")
  `BPTU_ASSERT_NEXT(a_spawn_count, clk, rst, spawn_acc && spawn_room, count == $past(count) + 1'b1, "spawn did not bump count")

endmodule
`default_nettype wire
